### rtl/particle_estimate_and_resampler_defines.svh
// Assertion helpers for the particle estimator.
`ifndef PARTICLE_ESTIMATE_AND_RESAMPLER_DEFINES_SVH
`define PARTICLE_ESTIMATE_AND_RESAMPLER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PEAR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PEAR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/pear_pkg.sv
package pear_pkg;

	// Command codes of the input word
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	// Register index carried in paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;

	localparam logic [16:0] WEIGHT_ONE     = 17'd65536;
	localparam logic [10:0] THRESH_RESET   = 11'd512;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_RD    = 12'b000000000010,
		ST_ACC   = 12'b000000000100,
		ST_THR   = 12'b000000001000,
		ST_DIVX  = 12'b000000010000,
		ST_DIVY  = 12'b000000100000,
		ST_DEC   = 12'b000001000000,
		ST_WADD  = 12'b000010000000,
		ST_WCMP  = 12'b000100000000,
		ST_SWEEP = 12'b001000000000,
		ST_FIN   = 12'b010000000000,
		ST_SPARE = 12'b100000000000
	} state_t;

endpackage

### rtl/pear_ram.sv
module pear_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/particle_estimate_and_resampler.sv
// Channel   Handshake                        Payload
// item      item_valid / item_stall          command, index, pos_x, pos_y, weight,
//                                            random_offset
// result    result_valid / result_stall      est_x, est_y, estimate_valid, did_resample,
//                                            particle_x, particle_y, particle_weight
// config    APB psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A load writes the particle stores on acceptance; a read registers its word in the RD state.
// A run sums the weighted positions and the weights, then does the two divisions,
// plus, when it resamples, the walk and the weight sweep.
// The sum pass and the walk are paced by the single read port of each particle memory.
// Reset clears control state and sets the threshold to 512; the particle stores stay undefined.
// New words stall while a run or read is in work or a result waits on a stall.
`include "particle_estimate_and_resampler_defines.svh"

module particle_estimate_and_resampler #(
	parameter int PARTICLE_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         command,
	input  logic [9:0]         index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [16:0]        weight,
	input  logic [15:0]        random_offset,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] est_x,
	output logic signed [15:0] est_y,
	output logic               estimate_valid,
	output logic               did_resample,
	output logic signed [15:0] particle_x,
	output logic signed [15:0] particle_y,
	output logic [16:0]        particle_weight,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW  = $clog2(PARTICLE_COUNT);
	localparam int TW  = 17 + AW;
	localparam int SW  = 33 + AW;
	localparam int QW  = 33 + AW;
	localparam int PW  = 11 + QW;
	localparam int NCW = TW + AW + 1;
	localparam int STW = $clog2(SW + 1);
	localparam logic [16:0] UNIFORM = 17'((65536 + PARTICLE_COUNT / 2) / PARTICLE_COUNT);

	pear_pkg::state_t state_q;

	logic [10:0]      thr_q;
	logic             bank_q;
	logic [AW:0]      cnt_q;
	logic [15:0]      off_q;
	logic             rd_ok_q;

	logic             rd_v_s1;
	logic             mul_v_s2;
	logic signed [33:0] mx_s2;
	logic signed [33:0] my_s2;
	logic [33:0]      mq_s2;
	logic [16:0]      w_s2;

	logic signed [SW-1:0] sx_q;
	logic signed [SW-1:0] sy_q;
	logic [TW-1:0]    tot_q;
	logic [QW-1:0]    sq_q;
	logic [PW-1:0]    prod_q;

	logic [SW-1:0]    dq_q;
	logic [TW:0]      rem_q;
	logic [STW-1:0]   step_q;
	logic             nx_q;
	logic             ny_q;
	logic [SW-1:0]    qx_q;

	logic [AW-1:0]    walk_i_q;
	logic [AW-1:0]    walk_j_q;
	logic [TW-1:0]    cum_q;
	logic             cp_v_s1;
	logic [AW:0]      cp_addr_s1;

	logic             res_valid_q;

	logic             accept;
	logic             in_range;
	logic [AW-1:0]    idx_addr;
	logic             x_we;
	logic [AW:0]      x_waddr;
	logic [AW:0]      x_raddr;
	logic [15:0]      x_wdata;
	logic [15:0]      y_wdata;
	logic [15:0]      x_rdata;
	logic [15:0]      y_rdata;
	logic             w_we;
	logic [AW-1:0]    w_waddr;
	logic [16:0]      w_wdata;
	logic [AW-1:0]    w_raddr;
	logic [16:0]      w_rdata;
	logic [16:0]      w_clamped;

	logic [TW:0]      rem_sh;
	logic             sub_ok;
	logic [SW-1:0]    dq_nx;
	logic [TW:0]      rem_nx;
	logic [SW-1:0]    mag_y;
	logic [NCW-1:0]   target;
	logic [NCW-1:0]   ncum;
	logic             advance;
	logic             last_step;

	// Saturate a rounded mean magnitude back to signed Q8.8
	function automatic logic [15:0] sat_mean(input logic neg, input logic [SW-1:0] q);
		logic [15:0] r;
		if (neg) begin
			r = (q > SW'(32768)) ? 16'h8000 : 16'(SW'(0) - q);
		end else begin
			r = (q > SW'(32767)) ? 16'h7fff : q[15:0];
		end
		return r;
	endfunction

	assign accept    = item_valid && !item_stall;
	assign in_range  = 32'(index) < PARTICLE_COUNT;
	assign idx_addr  = AW'(index);
	assign w_clamped = (weight > pear_pkg::WEIGHT_ONE) ? pear_pkg::WEIGHT_ONE : weight;
	assign item_stall = (state_q != pear_pkg::ST_IDLE) || (res_valid_q && result_stall);

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == pear_pkg::REG_THRESHOLD) ? {21'b0, thr_q} : 32'b0;

	// Divider step: shift one dividend bit into the remainder
	assign rem_sh    = {rem_q[TW-1:0], dq_q[SW-1]};
	assign sub_ok    = rem_sh >= {1'b0, tot_q};
	assign rem_nx    = sub_ok ? (rem_sh - {1'b0, tot_q}) : rem_sh;
	assign dq_nx     = {dq_q[SW-2:0], sub_ok};
	assign last_step = step_q == STW'(SW - 1);
	assign mag_y     = (sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q)) + SW'(tot_q >> 1);

	// Walk compare: target j*65536 + offset against N times running sum
	assign target  = NCW'({walk_j_q, off_q});
	assign ncum    = NCW'(cum_q) * NCW'(PARTICLE_COUNT);
	assign advance = (target > ncum) && (walk_i_q != AW'(PARTICLE_COUNT - 1));

	// Memory port selection
	always_comb begin
		x_we    = 1'b0;
		x_waddr = {bank_q, idx_addr};
		x_wdata = pos_x;
		y_wdata = pos_y;
		w_we    = 1'b0;
		w_waddr = idx_addr;
		w_wdata = w_clamped;
		x_raddr = {bank_q, idx_addr};
		w_raddr = idx_addr;
		if (accept && command == pear_pkg::CMD_LOAD && in_range) begin
			x_we = 1'b1;
			w_we = 1'b1;
		end
		if (cp_v_s1) begin
			x_we    = 1'b1;
			x_waddr = cp_addr_s1;
			x_wdata = x_rdata;
			y_wdata = y_rdata;
		end
		case (state_q)
			pear_pkg::ST_ACC: begin
				x_raddr = {bank_q, cnt_q[AW-1:0]};
				w_raddr = cnt_q[AW-1:0];
			end
			pear_pkg::ST_DEC: begin
				w_raddr = '0;
			end
			pear_pkg::ST_WCMP: begin
				x_raddr = {bank_q, walk_i_q};
				w_raddr = AW'(walk_i_q + AW'(1));
			end
			pear_pkg::ST_SWEEP: begin
				w_we    = 1'b1;
				w_waddr = cnt_q[AW-1:0];
				w_wdata = UNIFORM;
			end
			default: begin
			end
		endcase
	end

	pear_ram #(.WIDTH(16), .DEPTH(2 ** (AW + 1))) u_ram_x (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
		.raddr(x_raddr), .rdata(x_rdata)
	);

	pear_ram #(.WIDTH(16), .DEPTH(2 ** (AW + 1))) u_ram_y (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(y_wdata),
		.raddr(x_raddr), .rdata(y_rdata)
	);

	pear_ram #(.WIDTH(17), .DEPTH(PARTICLE_COUNT)) u_ram_w (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	// Multiply stage of the sum pass
	always_ff @(posedge clk) begin
		mx_s2 <= $signed(x_rdata) * $signed({1'b0, w_rdata});
		my_s2 <= $signed(y_rdata) * $signed({1'b0, w_rdata});
		mq_s2 <= 34'(w_rdata) * 34'(w_rdata);
		w_s2  <= w_rdata;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pear_pkg::ST_IDLE;
			thr_q       <= pear_pkg::THRESH_RESET;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			cp_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// Take a threshold write
			if (psel && penable && pwrite && pready
					&& paddr[2] == pear_pkg::REG_THRESHOLD) begin
				thr_q <= pwdata[10:0];
			end
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			rd_v_s1  <= (state_q == pear_pkg::ST_ACC) && (cnt_q != (AW+1)'(PARTICLE_COUNT));
			mul_v_s2 <= rd_v_s1;
			cp_v_s1  <= 1'b0;
			case (state_q)
				pear_pkg::ST_IDLE: begin
					if (accept) begin
						case (command)
							pear_pkg::CMD_READ: state_q <= pear_pkg::ST_RD;
							pear_pkg::CMD_RUN: begin
								cnt_q   <= '0;
								state_q <= pear_pkg::ST_ACC;
							end
							default: begin
							end
						endcase
					end
				end
				pear_pkg::ST_RD: begin
					res_valid_q <= 1'b1;
					state_q     <= pear_pkg::ST_IDLE;
				end
				pear_pkg::ST_ACC: begin
					if (cnt_q != (AW+1)'(PARTICLE_COUNT)) begin
						cnt_q <= cnt_q + (AW+1)'(1);
					end else if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= pear_pkg::ST_THR;
					end
				end
				pear_pkg::ST_THR: begin
					state_q <= (tot_q == '0) ? pear_pkg::ST_DEC : pear_pkg::ST_DIVX;
				end
				pear_pkg::ST_DIVX: begin
					if (last_step) begin
						state_q <= pear_pkg::ST_DIVY;
					end
				end
				pear_pkg::ST_DIVY: begin
					if (last_step) begin
						state_q <= pear_pkg::ST_DEC;
					end
				end
				pear_pkg::ST_DEC: begin
					state_q <= (prod_q > PW'(64'h1_0000_0000)) ? pear_pkg::ST_WADD
						: pear_pkg::ST_FIN;
				end
				pear_pkg::ST_WADD: state_q <= pear_pkg::ST_WCMP;
				pear_pkg::ST_WCMP: begin
					if (advance) begin
						state_q <= pear_pkg::ST_WADD;
					end else begin
						cp_v_s1 <= 1'b1;
						if (walk_j_q == AW'(PARTICLE_COUNT - 1)) begin
							cnt_q   <= '0;
							state_q <= pear_pkg::ST_SWEEP;
						end
					end
				end
				pear_pkg::ST_SWEEP: begin
					cnt_q <= cnt_q + (AW+1)'(1);
					if (cnt_q[AW-1:0] == AW'(PARTICLE_COUNT - 1)) begin
						bank_q  <= ~bank_q;
						state_q <= pear_pkg::ST_FIN;
					end
				end
				pear_pkg::ST_FIN: begin
					res_valid_q <= 1'b1;
					state_q     <= pear_pkg::ST_IDLE;
				end
				default: state_q <= pear_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers of a run and a read
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_q <= in_range;
			off_q   <= random_offset;
			sx_q    <= '0;
			sy_q    <= '0;
			tot_q   <= '0;
			sq_q    <= '0;
		end
		// Accumulate the weighted sums
		if (mul_v_s2) begin
			sx_q  <= sx_q + SW'(mx_s2);
			sy_q  <= sy_q + SW'(my_s2);
			tot_q <= tot_q + TW'(w_s2);
			sq_q  <= sq_q + QW'(mq_s2);
		end
		// Hold the last walk copy address
		cp_addr_s1 <= {~bank_q, walk_j_q};
		case (state_q)
			pear_pkg::ST_RD: begin
				est_x           <= '0;
				est_y           <= '0;
				estimate_valid  <= 1'b0;
				did_resample    <= 1'b0;
				particle_x      <= rd_ok_q ? x_rdata : 16'd0;
				particle_y      <= rd_ok_q ? y_rdata : 16'd0;
				particle_weight <= rd_ok_q ? w_rdata : 17'd0;
			end
			pear_pkg::ST_THR: begin
				prod_q <= PW'(thr_q) * PW'(sq_q);
				nx_q   <= sx_q[SW-1];
				dq_q   <= (sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q)) + SW'(tot_q >> 1);
				rem_q  <= '0;
				step_q <= '0;
			end
			pear_pkg::ST_DIVX: begin
				dq_q   <= dq_nx;
				rem_q  <= rem_nx;
				step_q <= step_q + STW'(1);
				if (last_step) begin
					qx_q   <= dq_nx;
					ny_q   <= sy_q[SW-1];
					dq_q   <= mag_y;
					rem_q  <= '0;
					step_q <= '0;
				end
			end
			pear_pkg::ST_DIVY: begin
				dq_q   <= dq_nx;
				rem_q  <= rem_nx;
				step_q <= step_q + STW'(1);
			end
			pear_pkg::ST_DEC: begin
				estimate_valid  <= tot_q != '0;
				est_x           <= (tot_q != '0) ? sat_mean(nx_q, qx_q) : 16'd0;
				est_y           <= (tot_q != '0) ? sat_mean(ny_q, dq_q) : 16'd0;
				did_resample    <= prod_q > PW'(64'h1_0000_0000);
				particle_x      <= '0;
				particle_y      <= '0;
				particle_weight <= '0;
				walk_i_q        <= '0;
				walk_j_q        <= '0;
				cum_q           <= '0;
			end
			pear_pkg::ST_WADD: begin
				cum_q <= cum_q + TW'(w_rdata);
			end
			pear_pkg::ST_WCMP: begin
				if (advance) begin
					walk_i_q <= AW'(walk_i_q + AW'(1));
				end else begin
					walk_j_q <= AW'(walk_j_q + AW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;

	`PEAR_ASSERT_IMP(a_walk_in_range, state_q == pear_pkg::ST_WCMP,
		(AW+1)'(walk_i_q) < (AW+1)'(PARTICLE_COUNT), "walk index past last particle")
	`PEAR_ASSERT_IMP(a_copy_in_walk, cp_v_s1,
		state_q == pear_pkg::ST_WCMP || state_q == pear_pkg::ST_SWEEP, "stray copy write")
	`PEAR_ASSERT(a_result_source, $rose(res_valid_q) |->
		$past(state_q == pear_pkg::ST_RD || state_q == pear_pkg::ST_FIN),
		"result from wrong state")

endmodule
